### rtl/core/rss_pkg.sv
// rss_pkg: shared types, widths and constants of the sky shade and accumulate pipeline
// no dependencies; imported by every module of the block

package rss_pkg;

    localparam int W        = 32;
    localparam int CH       = 3;
    localparam int CNT_W    = 16;
    localparam int RAD_W    = 2 * W;
    localparam int SQ_STEPS = W;
    localparam int Q_W      = 17;
    localparam int DIV_STEPS = Q_W;
    localparam int SKY_W    = 17;
    localparam int PROD_W   = SKY_W + 1 + W;
    localparam int RECIP_SH = 22;
    localparam int RECIP_W  = 19;

    localparam logic [7:0]       MAX_BOUNCE = 8'd16;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [SKY_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [RECIP_W-1:0] RECIP_10 = 19'd419431;

    typedef struct packed {
        logic [CH-1:0][W-1:0] atten;
        logic [CH-1:0][W-1:0] sum;
        logic [CNT_W-1:0]     count;
        logic                 live;
        logic                 y_neg;
    } t_side;

    typedef struct packed {
        logic [CH-1:0][W-1:0] sum;
        logic [CNT_W-1:0]     count;
        logic                 done;
    } t_res;

    function automatic logic [W-1:0] mag32(input logic [W-1:0] v);
        mag32 = v[W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

### rtl/core/rss_norm_sq.sv
// rss_norm_sq: three stages forming |x|, |y|, |z|, their squares and the squared length
// depends on rss_pkg

module rss_norm_sq import rss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [W-1:0]     i_dir_x,
    input  logic [W-1:0]     i_dir_y,
    input  logic [W-1:0]     i_dir_z,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [RAD_W-1:0] o_len_sq,
    output logic [W-1:0]     o_mag_y,
    output t_side            o_side
);

    logic [2:0]                r_valid;
    logic [CH-1:0][W-1:0]      r_mag;
    logic [CH-1:0][RAD_W-1:0]  r_sq;
    logic [RAD_W-1:0]          r_len_sq;
    logic [W-1:0]              r_my2;
    logic [W-1:0]              r_my3;
    t_side                     r_side1;
    t_side                     r_side2;
    t_side                     r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= mag32(i_dir_x);
            r_mag[1] <= mag32(i_dir_y);
            r_mag[2] <= mag32(i_dir_z);
            r_side1  <= i_side;
            for (int c = 0; c < CH; c++) begin
                r_sq[c] <= RAD_W'(r_mag[c]) * RAD_W'(r_mag[c]);
            end
            r_my2    <= r_mag[1];
            r_side2  <= r_side1;
            r_len_sq <= r_sq[0] + r_sq[1] + r_sq[2];
            r_my3    <= r_my2;
            r_side3  <= r_side2;
        end
    end

    assign o_valid  = r_valid[2];
    assign o_len_sq = r_len_sq;
    assign o_mag_y  = r_my3;
    assign o_side   = r_side3;

endmodule

### rtl/core/rss_sqrt.sv
// rss_sqrt: integer square root of the squared length, one root bit per pipeline stage
// depends on rss_pkg

module rss_sqrt import rss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [RAD_W-1:0] i_radicand,
    input  logic [W-1:0]     i_mag_y,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [W-1:0]     o_root,
    output logic [W-1:0]     o_mag_y,
    output t_side            o_side
);

    logic [SQ_STEPS-1:0] r_valid;
    logic [RAD_W-1:0]    r_rem  [SQ_STEPS];
    logic [W-1:0]        r_root [SQ_STEPS];
    logic [W-1:0]        r_my   [SQ_STEPS];
    t_side               r_side [SQ_STEPS];
    logic [RAD_W-1:0]    n_rem  [SQ_STEPS];
    logic [W-1:0]        n_root [SQ_STEPS];
    logic [W-1:0]        n_my   [SQ_STEPS];
    t_side               n_side [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam int B = SQ_STEPS - 1 - k;
        logic [RAD_W-1:0] rem_in;
        logic [W-1:0]     root_in;
        logic [RAD_W:0]   trial;
        logic [RAD_W:0]   diff;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in    = i_radicand;
            assign root_in   = '0;
            assign n_my[k]   = i_mag_y;
            assign n_side[k] = i_side;
        end else begin : g_next
            assign rem_in    = r_rem[k-1];
            assign root_in   = r_root[k-1];
            assign n_my[k]   = r_my[k-1];
            assign n_side[k] = r_side[k-1];
        end

        // root bits so far lie above bit B, so the trial term is an or
        assign trial     = ((RAD_W+1)'(root_in) << (B + 1)) | ((RAD_W+1)'(1) << (2 * B));
        assign diff      = {1'b0, rem_in} - trial;
        assign take      = ~diff[RAD_W];
        assign n_rem[k]  = take ? diff[RAD_W-1:0] : rem_in;
        assign n_root[k] = root_in | (W'(take) << B);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQ_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_my[k]   <= n_my[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_valid[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_mag_y = r_my[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

### rtl/core/rss_div.sv
// rss_div: restoring divider for |y| * 2^16 / length, one quotient bit per pipeline stage
// depends on rss_pkg

module rss_div import rss_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W-1:0]   i_num,
    input  logic [W-1:0]   i_den,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quo,
    output logic           o_den_zero,
    output t_side          o_side
);

    logic [DIV_STEPS-1:0] r_valid;
    logic [W-1:0]         r_rem  [DIV_STEPS];
    logic [Q_W-1:0]       r_quo  [DIV_STEPS];
    logic [W-1:0]         r_den  [DIV_STEPS];
    logic                 r_zero [DIV_STEPS];
    t_side                r_side [DIV_STEPS];
    logic [W-1:0]         n_rem  [DIV_STEPS];
    logic [Q_W-1:0]       n_quo  [DIV_STEPS];
    logic [W-1:0]         n_den  [DIV_STEPS];
    logic                 n_zero [DIV_STEPS];
    t_side                n_side [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [W-1:0]   rem_in;
        logic           dbit;
        logic [Q_W-1:0] quo_in;
        logic [W:0]     rem_sh;
        logic [W+1:0]   diff;
        logic           take;

        if (k == 0) begin : g_first
            // upper dividend bits start below the divisor since the quotient fits Q_W bits
            assign rem_in    = {1'b0, i_num[W-1:1]};
            assign dbit      = i_num[0];
            assign quo_in    = '0;
            assign n_den[k]  = i_den;
            assign n_zero[k] = (i_den == '0);
            assign n_side[k] = i_side;
        end else begin : g_next
            assign rem_in    = r_rem[k-1];
            assign dbit      = 1'b0;
            assign quo_in    = r_quo[k-1];
            assign n_den[k]  = r_den[k-1];
            assign n_zero[k] = r_zero[k-1];
            assign n_side[k] = r_side[k-1];
        end

        assign rem_sh   = {rem_in, dbit};
        assign diff     = {1'b0, rem_sh} - {2'b00, n_den[k]};
        assign take     = ~diff[W+1];
        assign n_rem[k] = take ? diff[W-1:0] : rem_sh[W-1:0];
        assign n_quo[k] = {quo_in[Q_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= n_den[k];
                r_zero[k] <= n_zero[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid    = r_valid[DIV_STEPS-1];
    assign o_quo      = r_quo[DIV_STEPS-1];
    assign o_den_zero = r_zero[DIV_STEPS-1];
    assign o_side     = r_side[DIV_STEPS-1];

endmodule

### rtl/core/rss_shade.sv
// rss_shade: gradient parameter, sky colour, attenuation product and saturating accumulate
// depends on rss_pkg

module rss_shade import rss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [Q_W-1:0]   i_quo,
    input  logic             i_den_zero,
    input  t_side            i_side,
    input  logic [CNT_W-1:0] i_samples,
    output logic             o_valid,
    output t_res             o_res
);

    logic [3:0]                 r_valid;
    logic [SKY_W-1:0]           r1_t;
    logic [SKY_W:0]             r1_t3;
    t_side                      r1_side;
    logic [CH-1:0][SKY_W-1:0]   r2_sky;
    t_side                      r2_side;
    logic [CH-1:0][PROD_W-1:0]  r3_prod;
    t_side                      r3_side;
    t_res                       r4_res;

    logic signed [Q_W:0]        y_norm;
    logic [Q_W:0]               t_sum;
    logic [SKY_W-1:0]           n_t;
    logic [SKY_W:0]             sky_r_full;
    logic [SKY_W+RECIP_W:0]     g_prod;
    logic [CH-1:0][SKY_W-1:0]   n_sky;
    logic [CH-1:0][W-1:0]       n_sum;
    logic [W:0]                 acc      [CH];
    logic [W:0]                 contrib  [CH];
    logic [CNT_W-1:0]           count4;

    // stage 1: signed normalized y and t = (y + 1) / 2
    always_comb begin
        if (i_den_zero) begin
            y_norm = '0;
        end else if (i_side.y_neg) begin
            y_norm = -$signed({1'b0, i_quo});
        end else begin
            y_norm = $signed({1'b0, i_quo});
        end
        t_sum = $unsigned(y_norm) + (Q_W+1)'(ONE_Q16);
        n_t   = t_sum[Q_W:1];
    end

    // stage 2: sky colour, 3t/10 through a reciprocal multiply
    always_comb begin
        sky_r_full = (SKY_W+1)'(2 * ONE_Q16) - {1'b0, r1_t};
        g_prod     = (SKY_W+RECIP_W+1)'(r1_t3) * (SKY_W+RECIP_W+1)'(RECIP_10);
        n_sky[0]   = sky_r_full[SKY_W:1];
        n_sky[1]   = ONE_Q16 - SKY_W'(g_prod[SKY_W+RECIP_W:RECIP_SH]);
        n_sky[2]   = ONE_Q16;
    end

    // stage 4: floor of product, add and clamp
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            contrib[c] = r3_side.live ? r3_prod[c][W+16:16] : '0;
            acc[c]     = {r3_side.sum[c][W-1], r3_side.sum[c]} + contrib[c];
            if (acc[c][W] != acc[c][W-1]) begin
                n_sum[c] = acc[c][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                n_sum[c] = acc[c][W-1:0];
            end
        end
        count4 = r3_side.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t    <= n_t;
            r1_t3   <= {1'b0, n_t} + {n_t, 1'b0};
            r1_side <= i_side;
            r2_sky  <= n_sky;
            r2_side <= r1_side;
            for (int c = 0; c < CH; c++) begin
                r3_prod[c] <= PROD_W'($signed({1'b0, r2_sky[c]}) * $signed(r2_side.atten[c]));
            end
            r3_side      <= r2_side;
            r4_res.sum   <= n_sum;
            r4_res.count <= count4;
            r4_res.done  <= (count4 == i_samples);
        end
    end

    assign o_valid = r_valid[3];
    assign o_res   = r4_res;

endmodule

### rtl/core/ray_sky_shade_accumulate_unit.sv
// ray_sky_shade_accumulate_unit: top level of the sky shade and pixel accumulate pipeline
// depends on rss_pkg, rss_norm_sq, rss_sqrt, rss_div and rss_shade

// Takes one escaped ray per clock while o_stall is low and returns one updated pixel
// word per ray, in order, after the squared length stages, the square root at one bit
// per stage, the divider at one quotient bit per stage, the shading and accumulate
// stages and the output register. Sustained rate is one word per cycle while i_stall
// is low. A skid register behind the output absorbs one word when the consumer stalls;
// while it is occupied the whole pipeline holds and o_stall is high. The per-pixel
// sample target is written through i_cfg_we / i_cfg_data and resets to 1; change it
// only while the pipeline is empty.

module ray_sky_shade_accumulate_unit import rss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [W-1:0]     i_dir_x,
    input  logic [W-1:0]     i_dir_y,
    input  logic [W-1:0]     i_dir_z,
    input  logic [W-1:0]     i_atten_r,
    input  logic [W-1:0]     i_atten_g,
    input  logic [W-1:0]     i_atten_b,
    input  logic [7:0]       i_bounce_count,
    input  logic [W-1:0]     i_sum_in_r,
    input  logic [W-1:0]     i_sum_in_g,
    input  logic [W-1:0]     i_sum_in_b,
    input  logic [CNT_W-1:0] i_count_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [W-1:0]     o_sum_out_r,
    output logic [W-1:0]     o_sum_out_g,
    output logic [W-1:0]     o_sum_out_b,
    output logic [CNT_W-1:0] o_count_out,
    output logic             o_pixel_done
);

    logic [CNT_W-1:0] r_samples;
    logic             r_out_valid;
    logic             r_skid_full;
    t_res             r_out;
    t_res             r_skid;

    logic             en;
    t_side            in_side;
    logic             ns_valid;
    logic [RAD_W-1:0] ns_len_sq;
    logic [W-1:0]     ns_mag_y;
    t_side            ns_side;
    logic             sq_valid;
    logic [W-1:0]     sq_root;
    logic [W-1:0]     sq_mag_y;
    t_side            sq_side;
    logic             dv_valid;
    logic [Q_W-1:0]   dv_quo;
    logic             dv_den_zero;
    t_side            dv_side;
    logic             sh_valid;
    t_res             sh_res;

    assign en = ~r_skid_full;

    always_comb begin
        in_side.atten = {i_atten_b, i_atten_g, i_atten_r};
        in_side.sum   = {i_sum_in_b, i_sum_in_g, i_sum_in_r};
        in_side.count = (i_count_in == COUNT_MAX) ? COUNT_MAX : i_count_in + 1'b1;
        in_side.live  = (i_bounce_count < MAX_BOUNCE);
        in_side.y_neg = i_dir_y[W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= 16'd1;
        end else if (i_cfg_we) begin
            r_samples <= i_cfg_data;
        end
    end

    rss_norm_sq u_norm_sq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_dir_x  (i_dir_x),
        .i_dir_y  (i_dir_y),
        .i_dir_z  (i_dir_z),
        .i_side   (in_side),
        .o_valid  (ns_valid),
        .o_len_sq (ns_len_sq),
        .o_mag_y  (ns_mag_y),
        .o_side   (ns_side)
    );

    rss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (ns_valid),
        .i_radicand (ns_len_sq),
        .i_mag_y    (ns_mag_y),
        .i_side     (ns_side),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_mag_y    (sq_mag_y),
        .o_side     (sq_side)
    );

    rss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (sq_valid),
        .i_num      (sq_mag_y),
        .i_den      (sq_root),
        .i_side     (sq_side),
        .o_valid    (dv_valid),
        .o_quo      (dv_quo),
        .o_den_zero (dv_den_zero),
        .o_side     (dv_side)
    );

    rss_shade u_shade (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (dv_valid),
        .i_quo      (dv_quo),
        .i_den_zero (dv_den_zero),
        .i_side     (dv_side),
        .i_samples  (r_samples),
        .o_valid    (sh_valid),
        .o_res      (sh_res)
    );

    // output register with one word of skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_skid_full | sh_valid;
            r_skid_full <= 1'b0;
        end else if (sh_valid && !r_skid_full) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_full ? r_skid : sh_res;
        end else if (sh_valid && !r_skid_full) begin
            r_skid <= sh_res;
        end
    end

    assign o_stall      = r_skid_full;
    assign o_valid      = r_out_valid;
    assign o_sum_out_r  = r_out.sum[0];
    assign o_sum_out_g  = r_out.sum[1];
    assign o_sum_out_b  = r_out.sum[2];
    assign o_count_out  = r_out.count;
    assign o_pixel_done = r_out.done;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid word held without an output word");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_out_valid && i_stall && sh_valid))
        else $error("skid filled without a stalled output word");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && !i_stall) |=> !r_skid_full && r_out_valid)
        else $error("skid word not moved to output");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.count != '0))
        else $error("output sample count is zero");

endmodule
